// File: rtl/core/multi_channel_health_watchdog_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the health watchdog.
// Both macros expect clk and rst to be visible at the place of use.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_HEALTH_WATCHDOG_MACROS_SVH
`define MULTI_CHANNEL_HEALTH_WATCHDOG_MACROS_SVH
`ifndef SYNTH
`define MCHW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("watchdog assertion failed");
`define MCHW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog implication failed");
`else
`define MCHW_ASSERT(label, prop)
`define MCHW_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// File: rtl/core/mchw_pkg.sv
// ----------------------------------------------------------------------------
// Health watchdog package
// Types, codes and constants shared by the watchdog files.
// ----------------------------------------------------------------------------
package mchw_pkg;

  localparam int NUM_CHANNELS = 7;
  localparam int IDX_W = $clog2(NUM_CHANNELS);

  // Event codes carried in the func field.
  localparam logic [3:0] FN_HEALTHY = 4'd0;
  localparam logic [3:0] FN_BUSY    = 4'd1;
  localparam logic [3:0] FN_IDLE    = 4'd2;
  localparam logic [3:0] FN_ENABLE  = 4'd3;
  localparam logic [3:0] FN_DISABLE = 4'd4;
  localparam logic [3:0] FN_SUSPEND = 4'd5;
  localparam logic [3:0] FN_RESUME  = 4'd6;
  localparam logic [3:0] FN_CHECK   = 4'd7;
  localparam logic [3:0] FN_START   = 4'd8;
  localparam logic [3:0] FN_SET_TMO = 4'd9;

  // Warning action codes.
  localparam logic [1:0] ACT_WARN     = 2'd0;
  localparam logic [1:0] ACT_DEFERRED = 2'd1;
  localparam logic [1:0] ACT_RESTART  = 2'd2;
  localparam logic [1:0] ACT_REBOOT   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_WARN_INTERVAL = 2'd0;
  localparam logic [1:0] REG_REBOOT_AFTER  = 2'd1;
  localparam logic [1:0] REG_RECOVERY      = 2'd2;

  localparam logic [31:0] WARN_INTERVAL_RST = 32'd60000;
  localparam logic [31:0] REBOOT_AFTER_RST  = 32'd900000;
  localparam logic [7:0]  DEPTH_MAX         = 8'd255;

  typedef struct packed {
    logic [3:0]  func;
    logic [2:0]  subsystem;
    logic [31:0] now_ms;
    logic        wifi_connected;
    logic        mqtt_connected;
    logic [6:0]  recovery_ok_mask;
    logic [31:0] timeout_value_ms;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  action;
    logic [2:0]  channel;
    logic [31:0] age_ms;
    logic [31:0] warning_total;
    logic [31:0] recovery_total;
    logic        guard_active;
    logic        feed_task_wdt;
    logic        any_overdue;
    logic        last;
  } out_item_t;

  // One channel's record as held in the state memory.
  typedef struct packed {
    logic [31:0] lht;
    logic [31:0] fot;
    logic [31:0] lwt;
    logic [31:0] wcnt;
    logic [31:0] rcnt;
    logic [31:0] tmo;
    logic        busy;
    logic        en;
    logic        ovd;
    logic        warned;
  } chan_rec_t;

  // Timeout a channel holds after reset.
  function automatic logic [31:0] default_timeout(input logic [IDX_W-1:0] idx);
    logic [31:0] t;
    case (idx)
      IDX_W'(0): t = 32'd120000;
      IDX_W'(1): t = 32'd180000;
      IDX_W'(2): t = 32'd180000;
      IDX_W'(3): t = 32'd600000;
      IDX_W'(4): t = 32'd300000;
      IDX_W'(5): t = 32'd300000;
      default:   t = 32'd30000;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/core/mchw_if.sv
// ----------------------------------------------------------------------------
// Watchdog stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mchw_in_if;
  logic               valid;
  logic               ready;
  mchw_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mchw_out_if;
  logic                valid;
  logic                ready;
  mchw_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/multi_channel_health_watchdog.sv
// ----------------------------------------------------------------------------
// Multi-channel health watchdog
// Heartbeat watchdog over seven channels with per-channel records in RAM.
// ----------------------------------------------------------------------------
// Items enter on req and results leave on rsp, both valid/ready; a transfer
// happens when valid and ready are high at a clock edge. Registers are
// written through cfg_we, cfg_index and cfg_data.
// Every item sweeps the channel records in the state memory: a read state and
// a read-modify-write state per channel, plus an emit step per warning result
// while the output register is free, then the closing status result. The
// next item is taken once the status has been loaded, even while it still
// waits on rsp. After reset the block writes default records into the memory,
// one per channel in the clearing state, before it takes its first item. When
// the receiver stalls, the sweep holds at the pending warning and resumes once
// the output is free.
// ----------------------------------------------------------------------------
module multi_channel_health_watchdog (
  input  logic        clk,
  input  logic        rst,
  mchw_in_if.sink     req,
  mchw_out_if.source  rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mchw_pkg::*;
  `include "multi_channel_health_watchdog_macros.svh"

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_PROC = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_STAT = 3'd5;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);

  logic [2:0]       state;
  logic [IDX_W-1:0] idx;
  in_item_t         itm;
  logic             do_st;
  logic [7:0]       depth;
  logic             started;
  logic             any;
  logic             rebooted;
  logic [31:0]      warn_interval;
  logic [31:0]      reboot_after;
  logic             recovery_present;
  out_item_t        pend0, pend1;
  logic [1:0]       pend_cnt;

  chan_rec_t rd_rec, wr_rec, clr_rec, upd;
  logic      we;
  logic      w1, w2;
  out_item_t r1, r2, stat;
  logic      slot_free, accept, load;
  out_item_t load_data;

  assign slot_free  = !rsp.valid || rsp.ready;
  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;

  // Channel record memory.
  mchw_ram #(.WIDTH($bits(chan_rec_t)), .DEPTH(NUM_CHANNELS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wr_rec),
    .raddr (idx),
    .rdata (rd_rec)
  );

  // Default record written during the clearing pass.
  always_comb begin
    clr_rec        = '0;
    clr_rec.en     = 1'b1;
    clr_rec.tmo    = default_timeout(idx);
  end

  // Per-channel update of the record read back from memory.
  always_comb begin
    logic hit;
    logic rec;
    logic [1:0] act1;
    upd  = rd_rec;
    w1   = 1'b0;
    w2   = 1'b0;
    act1 = ACT_WARN;
    rec  = 1'b0;
    hit  = (32'(itm.subsystem) < 32'(NUM_CHANNELS)) &&
           (32'(itm.subsystem) == 32'(idx));
    case (itm.func)
      FN_HEALTHY, FN_BUSY, FN_IDLE, FN_ENABLE: begin
        if (hit) begin
          if (itm.func == FN_BUSY || itm.func == FN_IDLE) begin
            upd.busy = (itm.func == FN_BUSY);
          end
          if (itm.func == FN_ENABLE) begin
            upd.en = 1'b1;
          end
          upd.lht = itm.now_ms;
          upd.fot = '0;
          upd.ovd = 1'b0;
        end
      end
      FN_DISABLE: begin
        if (hit) begin
          upd.en   = 1'b0;
          upd.fot  = '0;
          upd.ovd  = 1'b0;
          upd.busy = 1'b0;
        end
      end
      FN_RESUME: begin
        if (depth == 8'd0 && upd.busy) begin
          upd.lht = itm.now_ms;
        end
      end
      FN_START, FN_CHECK: begin
        if (do_st) begin
          upd.lht    = itm.now_ms;
          upd.fot    = '0;
          upd.lwt    = '0;
          upd.warned = 1'b0;
          upd.wcnt   = '0;
          upd.rcnt   = '0;
          upd.busy   = 1'b0;
          upd.ovd    = 1'b0;
        end
        if (itm.func == FN_CHECK) begin
          // Link flags count as heartbeats of the first two channels.
          if ((itm.wifi_connected && idx == IDX_W'(0)) ||
              (itm.mqtt_connected && idx == IDX_W'(1))) begin
            upd.lht = itm.now_ms;
            upd.fot = '0;
            upd.ovd = 1'b0;
          end
          // Overdue scan, skipped for channels after a reboot request.
          if (!rebooted && upd.en && !upd.busy &&
              (itm.now_ms - upd.lht) > upd.tmo) begin
            if (!upd.ovd) begin
              upd.fot = itm.now_ms;
            end
            upd.ovd = 1'b1;
            if (!upd.warned || (itm.now_ms - upd.lwt) >= warn_interval) begin
              upd.lwt    = itm.now_ms;
              upd.warned = 1'b1;
              upd.wcnt   = upd.wcnt + 32'd1;
              w1         = 1'b1;
              rec = (depth == 8'd0) && recovery_present &&
                    (32'(idx) < 32'd7) && itm.recovery_ok_mask[idx];
              if (rec) begin
                upd.rcnt = upd.rcnt + 32'd1;
                upd.lht  = itm.now_ms;
                upd.fot  = '0;
                upd.ovd  = 1'b0;
                act1     = ACT_RESTART;
              end else begin
                act1 = (depth != 8'd0) ? ACT_DEFERRED : ACT_WARN;
              end
            end
            if (depth == 8'd0 && upd.ovd &&
                (itm.now_ms - upd.fot) >= reboot_after) begin
              w2 = 1'b1;
            end
          end
        end
      end
      FN_SET_TMO: begin
        if (hit) begin
          upd.tmo = itm.timeout_value_ms;
        end
      end
      default: begin
      end
    endcase

    r1                = '0;
    r1.kind           = 1'b1;
    r1.action         = act1;
    r1.channel        = 3'(idx);
    r1.age_ms         = itm.now_ms - upd.lht;
    r1.warning_total  = upd.wcnt;
    r1.recovery_total = upd.rcnt;
    r1.guard_active   = (depth != 8'd0);
    r2                = r1;
    r2.action         = ACT_REBOOT;
  end

  assign we     = (state == S_CLR) || (state == S_PROC);
  assign wr_rec = (state == S_CLR) ? clr_rec : upd;

  // Closing status result.
  always_comb begin
    stat            = '0;
    stat.guard_active = (depth != 8'd0);
    stat.any_overdue = any;
    stat.last       = 1'b1;
    case (itm.func)
      FN_SUSPEND: stat.feed_task_wdt = started;
      FN_RESUME:  stat.feed_task_wdt = started && (depth == 8'd0);
      FN_CHECK:   stat.feed_task_wdt = !rebooted && (!any || depth != 8'd0);
      default:    stat.feed_task_wdt = 1'b0;
    endcase
  end

  assign load      = slot_free && ((state == S_EMIT) || (state == S_STAT));
  assign load_data = (state == S_STAT) ? stat : pend0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (load) begin
      rsp.data <= load_data;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_interval    <= WARN_INTERVAL_RST;
      reboot_after     <= REBOOT_AFTER_RST;
      recovery_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WARN_INTERVAL: warn_interval    <= cfg_data;
        REG_REBOOT_AFTER:  reboot_after     <= cfg_data;
        REG_RECOVERY:      recovery_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer over the channel records.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      idx      <= '0;
      depth    <= '0;
      started  <= 1'b0;
      any      <= 1'b0;
      rebooted <= 1'b0;
      pend_cnt <= '0;
      do_st    <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          if (idx == IDX_LAST) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            itm      <= req.data;
            idx      <= '0;
            any      <= 1'b0;
            rebooted <= 1'b0;
            do_st    <= (req.data.func == FN_START) ||
                        (req.data.func == FN_CHECK && !started);
            if (req.data.func == FN_START || req.data.func == FN_CHECK) begin
              started <= 1'b1;
            end
            if (req.data.func == FN_SUSPEND && depth != DEPTH_MAX) begin
              depth <= depth + 8'd1;
            end
            if (req.data.func == FN_RESUME && depth != 8'd0) begin
              depth <= depth - 8'd1;
            end
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_PROC;
        end
        S_PROC: begin
          if (w1 || w2) begin
            any <= 1'b1;
          end else if (itm.func == FN_CHECK && !rebooted && upd.ovd &&
                       !rd_rec.busy && upd.en && upd.ovd != rd_rec.ovd) begin
            any <= 1'b1;
          end else if (itm.func == FN_CHECK && !rebooted && upd.ovd &&
                       (upd.fot == itm.now_ms || rd_rec.ovd) && upd.en &&
                       !upd.busy && (itm.now_ms - upd.lht) > upd.tmo) begin
            any <= 1'b1;
          end
          if (w2) begin
            rebooted <= 1'b1;
          end
          pend0    <= w1 ? r1 : r2;
          pend1    <= r2;
          pend_cnt <= 2'(w1) + 2'(w2);
          if (w1 || w2) begin
            state <= S_EMIT;
          end else if (idx == IDX_LAST) begin
            state <= S_STAT;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_RD;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            pend0    <= pend1;
            pend_cnt <= pend_cnt - 2'd1;
            if (pend_cnt == 2'd1) begin
              if (idx == IDX_LAST) begin
                state <= S_STAT;
              end else begin
                idx   <= idx + IDX_W'(1);
                state <= S_RD;
              end
            end
          end
        end
        S_STAT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer.
  `MCHW_ASSERT_IMPL(a_write_states, we, (state == S_CLR || state == S_PROC))
  `MCHW_ASSERT(a_pend_bound, (pend_cnt <= 2'd2))
  `MCHW_ASSERT_IMPL(a_emit_pending, (state == S_EMIT), (pend_cnt != 2'd0))
  `MCHW_ASSERT_IMPL(a_status_ends, (load && state == S_STAT),
                    (load_data.last && !load_data.kind))
endmodule

// File: rtl/core/mchw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mchw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: dv/multi_channel_health_watchdog_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Health watchdog testbench
// Drives event items into the watchdog, predicts the warnings and status
// results that each transfer should produce, and compares every result field
// by field. Runs directed cases, then random event streams under several
// register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module multi_channel_health_watchdog_tb;
  import mchw_pkg::*;

  localparam int CHANS = 7;
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  mchw_in_if  req ();
  mchw_out_if rsp ();

  multi_channel_health_watchdog dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the watchdog's registers and channel records.
  logic [31:0] warn_interval;
  logic [31:0] reboot_after;
  logic        recovery_en;
  logic [31:0] healthy_at  [CHANS];
  logic [31:0] overdue_at  [CHANS];
  logic [31:0] warned_at   [CHANS];
  logic [31:0] warn_count  [CHANS];
  logic [31:0] recov_count [CHANS];
  logic [31:0] tmo_limit   [CHANS];
  logic        is_busy     [CHANS];
  logic        is_enabled  [CHANS];
  logic        is_overdue  [CHANS];
  logic        has_warned  [CHANS];
  logic [7:0]  guard_depth;
  logic        is_started;

  out_item_t   pending_results[$];
  int          error_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic [31:0] clock_ms;

  // Clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog on the whole run.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver stalls.
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Reset values of the shadow state.
  task automatic reset_shadow();
    logic [31:0] defaults [CHANS];
    defaults = '{32'd120000, 32'd180000, 32'd180000, 32'd600000,
                 32'd300000, 32'd300000, 32'd30000};
    warn_interval = WARN_INTERVAL_RST;
    reboot_after  = REBOOT_AFTER_RST;
    recovery_en   = 1'b0;
    for (int i = 0; i < CHANS; i++) begin
      healthy_at[i]  = '0;
      overdue_at[i]  = '0;
      warned_at[i]   = '0;
      warn_count[i]  = '0;
      recov_count[i] = '0;
      tmo_limit[i]   = defaults[i];
      is_busy[i]     = 1'b0;
      is_enabled[i]  = 1'b1;
      is_overdue[i]  = 1'b0;
      has_warned[i]  = 1'b0;
    end
    guard_depth = '0;
    is_started  = 1'b0;
  endtask

  function automatic void set_healthy(int ch, logic [31:0] now);
    healthy_at[ch] = now;
    overdue_at[ch] = '0;
    is_overdue[ch] = 1'b0;
  endfunction

  function automatic void start_watchdog(logic [31:0] now);
    for (int i = 0; i < CHANS; i++) begin
      healthy_at[i]  = now;
      overdue_at[i]  = '0;
      warned_at[i]   = '0;
      has_warned[i]  = 1'b0;
      warn_count[i]  = '0;
      recov_count[i] = '0;
      is_busy[i]     = 1'b0;
      is_overdue[i]  = 1'b0;
    end
    is_started = 1'b1;
  endfunction

  function automatic void push_warning(int ch, logic [1:0] act, logic [31:0] now);
    out_item_t w;
    w = '0;
    w.kind           = 1'b1;
    w.action         = act;
    w.channel        = ch[2:0];
    w.age_ms         = now - healthy_at[ch];
    w.warning_total  = warn_count[ch];
    w.recovery_total = recov_count[ch];
    w.guard_active   = (guard_depth != 0);
    pending_results.push_back(w);
  endfunction

  // Works out the results of one event and advances the shadow state.
  function automatic void predict_event(in_item_t it);
    out_item_t   st;
    logic        in_range;
    int          ch;
    logic        feed;
    logic        any;
    logic        reboot;
    logic        recovered;
    logic [31:0] now;
    logic [31:0] age;
    in_range = (it.subsystem < CHANS);
    ch       = in_range ? int'(it.subsystem) : 0;
    now      = it.now_ms;
    feed     = 1'b0;
    any      = 1'b0;
    case (it.func)
      FN_HEALTHY: if (in_range) set_healthy(ch, now);
      FN_BUSY, FN_IDLE: begin
        if (in_range) begin
          is_busy[ch] = (it.func == FN_BUSY);
          set_healthy(ch, now);
        end
      end
      FN_ENABLE: begin
        if (in_range) begin
          is_enabled[ch] = 1'b1;
          set_healthy(ch, now);
        end
      end
      FN_DISABLE: begin
        if (in_range) begin
          is_enabled[ch] = 1'b0;
          overdue_at[ch] = '0;
          is_overdue[ch] = 1'b0;
          is_busy[ch]    = 1'b0;
        end
      end
      FN_SUSPEND: begin
        if (guard_depth != DEPTH_MAX) guard_depth++;
        feed = is_started;
      end
      FN_RESUME: begin
        if (guard_depth != 0) guard_depth--;
        if (guard_depth == 0) begin
          for (int i = 0; i < CHANS; i++)
            if (is_busy[i]) healthy_at[i] = now;
          feed = is_started;
        end
      end
      FN_CHECK: begin
        reboot = 1'b0;
        if (!is_started) start_watchdog(now);
        if (it.wifi_connected) set_healthy(0, now);
        if (it.mqtt_connected) set_healthy(1, now);
        for (int i = 0; i < CHANS && !reboot; i++) begin
          if (!is_enabled[i] || is_busy[i]) continue;
          age = now - healthy_at[i];
          if (age <= tmo_limit[i]) continue;
          if (!is_overdue[i]) overdue_at[i] = now;
          is_overdue[i] = 1'b1;
          any = 1'b1;
          if (!has_warned[i] || (now - warned_at[i]) >= warn_interval) begin
            warned_at[i]  = now;
            has_warned[i] = 1'b1;
            warn_count[i]++;
            recovered = (guard_depth == 0) && recovery_en && it.recovery_ok_mask[i];
            if (recovered) begin
              recov_count[i]++;
              set_healthy(i, now);
              push_warning(i, ACT_RESTART, now);
            end else begin
              push_warning(i, (guard_depth != 0) ? ACT_DEFERRED : ACT_WARN, now);
            end
          end
          if (guard_depth == 0 && is_overdue[i] && (now - overdue_at[i]) >= reboot_after) begin
            push_warning(i, ACT_REBOOT, now);
            reboot = 1'b1;
          end
        end
        feed = !reboot && (!any || guard_depth != 0);
      end
      FN_START: start_watchdog(now);
      FN_SET_TMO: if (in_range) tmo_limit[ch] = it.timeout_value_ms;
      default: ;
    endcase
    st = '0;
    st.guard_active  = (guard_depth != 0);
    st.feed_task_wdt = feed;
    st.any_overdue   = any;
    st.last          = 1'b1;
    pending_results.push_back(st);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      error_count++;
    end
  endtask

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    out_item_t exp_r;
    out_item_t got_r;
    if (!rst && rsp.valid && rsp.ready) begin
      got_r = rsp.data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got_r);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("kind", 32'(exp_r.kind), 32'(got_r.kind));
        check_field("action", 32'(exp_r.action), 32'(got_r.action));
        check_field("channel", 32'(exp_r.channel), 32'(got_r.channel));
        check_field("age_ms", exp_r.age_ms, got_r.age_ms);
        check_field("warning_total", exp_r.warning_total, got_r.warning_total);
        check_field("recovery_total", exp_r.recovery_total, got_r.recovery_total);
        check_field("guard_active", 32'(exp_r.guard_active), 32'(got_r.guard_active));
        check_field("feed_task_wdt", 32'(exp_r.feed_task_wdt),
                    32'(got_r.feed_task_wdt));
        check_field("any_overdue", 32'(exp_r.any_overdue), 32'(got_r.any_overdue));
        check_field("last", 32'(exp_r.last), 32'(got_r.last));
      end
    end
  end

  // Sends one event; entered and left at a falling edge.
  task automatic send_event(in_item_t it);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= it;
    do @(posedge clk); while (!req.ready);
    predict_event(it);
    @(negedge clk);
  endtask

  task automatic send_simple(logic [3:0] fn, logic [2:0] sub, logic [31:0] now);
    in_item_t it;
    it = '0;
    it.func      = fn;
    it.subsystem = sub;
    it.now_ms    = now;
    send_event(it);
  endtask

  // Waits until every predicted result has been seen and the block is idle.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_WARN_INTERVAL: warn_interval = val;
      REG_REBOOT_AFTER:  reboot_after  = val;
      REG_RECOVERY:      recovery_en   = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [31:0] interval, logic [31:0] reboot, logic rec);
    drain();
    write_reg(REG_WARN_INTERVAL, interval);
    write_reg(REG_REBOOT_AFTER, reboot);
    write_reg(REG_RECOVERY, {31'd0, rec});
  endtask

  // Every event code, channel bounds, timestamp extremes and overdue paths.
  task automatic test_directed();
    in_item_t it;
    send_simple(FN_SUSPEND, 3'd0, 32'd0);
    send_simple(FN_RESUME, 3'd0, 32'd0);
    send_simple(FN_CHECK, 3'd0, 32'd0);
    send_simple(FN_HEALTHY, 3'd7, 32'd100);
    send_simple(FN_BUSY, 3'd2, 32'hFFFF_FFFF);
    send_simple(FN_IDLE, 3'd2, 32'd5);
    send_simple(FN_DISABLE, 3'd6, 32'd10);
    send_simple(FN_ENABLE, 3'd6, 32'd0);
    it = '0;
    it.func = FN_SET_TMO;
    it.subsystem = 3'd3;
    it.timeout_value_ms = 32'hFFFF_FFFF;
    send_event(it);
    it.subsystem = 3'd4;
    it.timeout_value_ms = 32'd0;
    send_event(it);
    it.subsystem = 3'd7;
    send_event(it);
    for (int f = 10; f < 16; f++) send_simple(f[3:0], 3'd1, 32'd77);
    send_simple(FN_BUSY, 3'd5, 32'd20);
    // Overdue scans over several channels at once, with and without heartbeats.
    it = '0;
    it.func = FN_CHECK;
    it.now_ms = 32'd1_000_000;
    it.wifi_connected = 1'b1;
    it.recovery_ok_mask = 7'h7F;
    send_event(it);
    send_simple(FN_SUSPEND, 3'd0, 32'd1_000_001);
    it.now_ms = 32'd1_100_000;
    it.wifi_connected = 1'b0;
    it.mqtt_connected = 1'b1;
    send_event(it);
    send_simple(FN_RESUME, 3'd0, 32'd1_200_000);
    it.now_ms = 32'd2_100_000;
    send_event(it);
    send_simple(FN_START, 3'd0, 32'hFFFF_0000);
    it.now_ms = 32'd200_000;
    send_event(it);
  endtask

  // Nested suspends, an overdue scan while suspended, and resume past zero.
  task automatic test_suspend_depth();
    repeat (5) send_simple(FN_SUSPEND, 3'd0, clock_ms);
    send_simple(FN_CHECK, 3'd0, clock_ms + 32'd700_000);
    repeat (6) send_simple(FN_RESUME, 3'd0, clock_ms + 32'd700_001);
    clock_ms += 32'd700_001;
  endtask

  // Random event streams with a mostly advancing clock.
  task automatic test_random_events(int count);
    in_item_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 36) it.func = FN_CHECK;
      else if (pick < 54) it.func = FN_HEALTHY;
      else if (pick < 60) it.func = FN_BUSY;
      else if (pick < 66) it.func = FN_IDLE;
      else if (pick < 70) it.func = FN_ENABLE;
      else if (pick < 74) it.func = FN_DISABLE;
      else if (pick < 79) it.func = FN_SUSPEND;
      else if (pick < 86) it.func = FN_RESUME;
      else if (pick < 88) it.func = FN_START;
      else if (pick < 96) it.func = FN_SET_TMO;
      else it.func = 4'($urandom_range(10, 15));
      it.subsystem = 3'($urandom_range(0, 7));
      pick = $urandom_range(99);
      if (pick < 4) clock_ms = $urandom;
      else if (pick < 8) clock_ms -= $urandom_range(0, 100_000);
      else clock_ms += $urandom_range(0, 250_000);
      it.now_ms = clock_ms;
      it.wifi_connected = 1'($urandom_range(0, 1));
      it.mqtt_connected = 1'($urandom_range(0, 1));
      it.recovery_ok_mask = 7'($urandom);
      it.timeout_value_ms = ($urandom_range(9) == 0) ? $urandom
                                                     : $urandom_range(10_000, 400_000);
      send_event(it);
    end
  endtask

  initial begin
    error_count = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    clock_ms    = 32'd2_500_000;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_WARN_INTERVAL;
    cfg_data    = '0;
    req.valid   = 1'b0;
    req.data    = '0;
    reset_shadow();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 26;
    rx_idle_pct = 69;
    test_directed();
    test_random_events(60);
    apply_settings(32'd0, 32'hFFFF_FFFF, 1'b1);
    test_random_events(60);

    tx_idle_pct = 69;
    rx_idle_pct = 26;
    apply_settings(32'hFFFF_FFFF, 32'd0, 1'b0);
    test_random_events(57);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_settings(32'd30_000, 32'd500_000, 1'b1);
    test_suspend_depth();
    test_random_events(56);

    drain();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mchw_pkg.sv
rtl/core/mchw_if.sv
rtl/core/mchw_ram.sv
rtl/core/multi_channel_health_watchdog.sv
dv/multi_channel_health_watchdog_tb.sv
